FILE: rtl/core/cfr_pkg.sv
`default_nettype none
package cfr_pkg;

   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_DATA   = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_INVALID  = 2'd0,
      ST_OK       = 2'd1,
      ST_ACCEPTED = 2'd2,
      ST_COMPLETE = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  seg_num;
      logic [7:0]  seg_len;
      logic [31:0] generation;
      logic [7:0]  data_byte;
      logic [7:0]  read_address;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_data;
      logic       active;
   } rsp_type;

   localparam int OFFSET_W = 16;

endpackage
`default_nettype wire

FILE: rtl/core/chunked_frame_reassembly_unit.sv
`default_nettype none
// Rebuilds one frame of FRAME_BYTES bytes from CHUNK_COUNT numbered chunks of
// CHUNK_BYTES bytes (the last one short). busy is always low: one word is taken
// every cycle and its result, if it has one, appears with rsp_valid in the next
// cycle, held in the single register stage after the header/data checks and in
// the registered read port of the frame store. The receiver cannot stall
// and must take every result in the cycle it is shown. A data word that is not
// the last byte of its chunk gives no result.
module chunked_frame_reassembly_unit #(
   parameter int FRAME_BYTES = 256,
   parameter int CHUNK_BYTES = 60,
   parameter int CHUNK_COUNT = 5
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire cfr_pkg::req_type req_item,
   output logic                 rsp_valid,
   output cfr_pkg::rsp_type     rsp_item
);
   import cfr_pkg::*;

   localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int WP_W   = $clog2(FRAME_BYTES + 1);
   localparam int BL_W   = $clog2(CHUNK_BYTES + 1);
   localparam int PI_W   = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
   localparam logic [OFFSET_W-1:0] FRAME_LEN = OFFSET_W'(FRAME_BYTES);
   localparam logic [OFFSET_W-1:0] CHUNK_LEN = OFFSET_W'(CHUNK_BYTES);

   logic [CHUNK_COUNT-1:0] mask_ff, mask_in;
   logic                   active_ff, active_in;
   logic [31:0]            gen_ff, gen_in;
   logic                   pend_ff, pend_in;
   logic [PI_W-1:0]        pidx_ff, pidx_in;
   logic [WP_W-1:0]        wp_ff, wp_in;
   logic [BL_W-1:0]        bl_ff, bl_in;
   logic                   valid_ff, valid_in;
   logic [1:0]             status_ff, status_in;
   logic                   rd_ok_ff, rd_ok_in;

   logic                   accept;
   logic [OFFSET_W-1:0]    offset;
   logic [OFFSET_W-1:0]    remain;
   logic [OFFSET_W-1:0]    exp_size;
   logic                   hdr_fail;
   logic [CHUNK_COUNT-1:0] base_mask;
   logic [CHUNK_COUNT-1:0] done_mask;
   logic                   wr_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [7:0]             rd_q;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign offset = OFFSET_W'(req_item.seg_num) * CHUNK_LEN;
   assign remain = FRAME_LEN - offset;
   assign exp_size = (offset >= FRAME_LEN) ? '0 :
                     ((remain > CHUNK_LEN) ? CHUNK_LEN : remain);
   assign rd_addr = ADDR_W'({{ADDR_W{1'b0}}, req_item.read_address});

   always_comb begin
      mask_in   = mask_ff;
      active_in = active_ff;
      gen_in    = gen_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      wp_in     = wp_ff;
      bl_in     = bl_ff;
      valid_in  = 1'b0;
      status_in = ST_INVALID;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      hdr_fail  = 1'b0;
      base_mask = mask_ff;
      done_mask = mask_ff;
      if (accept) begin
         valid_in = 1'b1;
         unique case (op_type'(req_item.op))
            OP_HEADER: begin
               hdr_fail = (32'(req_item.seg_num) >= 32'(CHUNK_COUNT)) ||
                          (OFFSET_W'(req_item.seg_len) != exp_size) ||
                          ((req_item.seg_num != 8'd0) &&
                           (!active_ff || (gen_ff != req_item.generation)));
               pend_in = 1'b0;
               if (hdr_fail) begin
                  mask_in   = '0;
                  gen_in    = '0;
                  active_in = 1'b0;
               end else begin
                  if (req_item.seg_num == 8'd0) begin
                     base_mask = '0;
                     active_in = 1'b1;
                     gen_in    = req_item.generation;
                  end
                  pidx_in = req_item.seg_num[PI_W-1:0];
                  wp_in   = offset[WP_W-1:0];
                  bl_in   = req_item.seg_len[BL_W-1:0];
                  mask_in = base_mask;
                  if (req_item.seg_len == 8'd0) begin
                     done_mask = base_mask |
                                 (CHUNK_COUNT'(1) << req_item.seg_num[PI_W-1:0]);
                     if (&done_mask) begin
                        mask_in   = '0;
                        gen_in    = '0;
                        active_in = 1'b0;
                        status_in = ST_COMPLETE;
                     end else begin
                        mask_in   = done_mask;
                        status_in = ST_ACCEPTED;
                     end
                  end else begin
                     pend_in   = 1'b1;
                     status_in = ST_OK;
                  end
               end
            end
            OP_DATA: begin
               if (pend_ff) begin
                  wr_en = 1'b1;
                  wp_in = wp_ff + WP_W'(1);
                  bl_in = bl_ff - BL_W'(1);
                  if (bl_ff == BL_W'(1)) begin
                     pend_in   = 1'b0;
                     done_mask = mask_ff | (CHUNK_COUNT'(1) << pidx_ff);
                     if (&done_mask) begin
                        mask_in   = '0;
                        gen_in    = '0;
                        active_in = 1'b0;
                        status_in = ST_COMPLETE;
                     end else begin
                        mask_in   = done_mask;
                        status_in = ST_ACCEPTED;
                     end
                  end else begin
                     valid_in = 1'b0;
                  end
               end
            end
            OP_READ: begin
               if (32'(req_item.read_address) < 32'(FRAME_BYTES)) begin
                  rd_ok_in  = 1'b1;
                  status_in = ST_OK;
               end
            end
            OP_NONE: begin
               status_in = ST_INVALID;
            end
            default: begin
               status_in = ST_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         active_ff <= 1'b0;
         gen_ff    <= '0;
         pend_ff   <= 1'b0;
         pidx_ff   <= '0;
         wp_ff     <= '0;
         bl_ff     <= '0;
         valid_ff  <= 1'b0;
         status_ff <= ST_INVALID;
         rd_ok_ff  <= 1'b0;
      end else begin
         mask_ff   <= mask_in;
         active_ff <= active_in;
         gen_ff    <= gen_in;
         pend_ff   <= pend_in;
         pidx_ff   <= pidx_in;
         wp_ff     <= wp_in;
         bl_ff     <= bl_in;
         valid_ff  <= valid_in;
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   cfr_store #(
      .DEPTH  (FRAME_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff[ADDR_W-1:0]),
      .wr_data (req_item.data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   assign rsp_valid          = valid_ff;
   assign rsp_item.status    = status_ff;
   assign rsp_item.read_data = rd_ok_ff ? rd_q : 8'd0;
   assign rsp_item.active    = active_ff;

endmodule
`default_nettype wire

FILE: rtl/core/cfr_store.sv
`default_nettype none
module cfr_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: sim/tb_chunked_frame_reassembly_unit.sv
`timescale 1ns / 1ps

module tb_chunked_frame_reassembly_unit;
   import cfr_pkg::*;

   localparam int FRAME_BYTES = 256;
   localparam int CHUNK_BYTES = 60;
   localparam int CHUNK_COUNT = 5;
   localparam int WORD_TARGET = 1300;

   typedef struct {
      req_type word;
      bit      has_rsp;
      rsp_type rsp;
      int      gap;
   } word_job_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   chunked_frame_reassembly_unit #(
      .FRAME_BYTES(FRAME_BYTES),
      .CHUNK_BYTES(CHUNK_BYTES),
      .CHUNK_COUNT(CHUNK_COUNT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the reassembly state
   logic [7:0]             shadow_store [FRAME_BYTES];
   bit   [FRAME_BYTES-1:0] store_written = '0;
   logic [CHUNK_COUNT-1:0] got_mask = '0;
   bit                     sess_active = 1'b0;
   logic [31:0]            sess_gen = '0;
   bit                     pend = 1'b0;
   int                     pend_idx = 0;
   int                     wptr = 0;
   int                     bytes_due = 0;

   word_job_type pending_words[$];
   rsp_type      owed_replies[$];
   word_job_type cur;
   int           words_sent = 0;
   int           gap_left = 0;
   int           words_queued = 0;
   int           words_taken = 0;
   int           error_count = 0;
   bit           calm = 1'b0;

   function automatic int chunk_len(int idx);
      int offset;
      offset = idx * CHUNK_BYTES;
      if (offset >= FRAME_BYTES) return 0;
      return (FRAME_BYTES - offset > CHUNK_BYTES) ? CHUNK_BYTES : FRAME_BYTES - offset;
   endfunction

   function automatic void drop_session();
      got_mask = '0;
      sess_gen = '0;
      sess_active = 1'b0;
      pend = 1'b0;
   endfunction

   function automatic status_type close_chunk();
      pend = 1'b0;
      got_mask[pend_idx] = 1'b1;
      if (&got_mask) begin
         drop_session();
         return ST_COMPLETE;
      end
      return ST_ACCEPTED;
   endfunction

   function automatic word_job_type forecast_word(req_type w);
      word_job_type j;
      j.word = w;
      j.has_rsp = 1'b1;
      j.rsp = '0;
      j.gap = 0;
      case (w.op)
         OP_HEADER: begin
            if (w.seg_num == 0) drop_session();
            pend = 1'b0;
            if (w.seg_num >= CHUNK_COUNT || w.seg_len != chunk_len(w.seg_num)) begin
               drop_session();
            end else if (w.seg_num != 0 && (!sess_active || sess_gen != w.generation)) begin
               drop_session();
            end else begin
               if (w.seg_num == 0) begin
                  sess_active = 1'b1;
                  sess_gen = w.generation;
               end
               pend = 1'b1;
               pend_idx = w.seg_num;
               wptr = pend_idx * CHUNK_BYTES;
               bytes_due = w.seg_len;
               j.rsp.status = (bytes_due == 0) ? close_chunk() : ST_OK;
            end
         end
         OP_DATA: begin
            if (pend) begin
               if (wptr < FRAME_BYTES) begin
                  shadow_store[wptr] = w.data_byte;
                  store_written[wptr] = 1'b1;
               end
               wptr++;
               bytes_due--;
               if (bytes_due != 0) j.has_rsp = 1'b0;
               else j.rsp.status = close_chunk();
            end
         end
         OP_READ: begin
            if (w.read_address < FRAME_BYTES) begin
               j.rsp.status = ST_OK;
               j.rsp.read_data = shadow_store[w.read_address];
            end
         end
         default: ;
      endcase
      j.rsp.active = sess_active;
      return j;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic req_type noise_word(logic [1:0] op);
      req_type w;
      w.op = op;
      w.seg_num = 8'($urandom);
      w.seg_len = 8'($urandom);
      w.generation = $urandom;
      w.data_byte = 8'($urandom);
      w.read_address = 8'($urandom);
      return w;
   endfunction

   function automatic int written_addr();
      int a;
      int base;
      if (store_written == '0) return -1;
      base = $urandom_range(0, FRAME_BYTES - 1);
      for (int k = 0; k < FRAME_BYTES; k++) begin
         a = (base + k) % FRAME_BYTES;
         if (store_written[a]) return a;
      end
      return -1;
   endfunction

   function automatic logic [31:0] pick_tag();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hffff_ffff;
      return $urandom;
   endfunction

   task automatic push_word(req_type w);
      word_job_type j;
      j = forecast_word(w);
      j.gap = pick_gap();
      pending_words.push_back(j);
      words_queued++;
   endtask

   task automatic send_header(int idx, int size, logic [31:0] tag);
      req_type w;
      w = noise_word(OP_HEADER);
      w.seg_num = 8'(idx);
      w.seg_len = 8'(size);
      w.generation = tag;
      push_word(w);
   endtask

   task automatic send_byte(logic [7:0] b);
      req_type w;
      w = noise_word(OP_DATA);
      w.data_byte = b;
      push_word(w);
   endtask

   task automatic send_read(int addr);
      req_type w;
      if (addr >= 0) begin
         w = noise_word(OP_READ);
         w.read_address = 8'(addr);
         push_word(w);
      end
   endtask

   task automatic send_bytes(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 3) send_read(written_addr());
         r = $urandom_range(0, 9);
         send_byte(r == 0 ? 8'h00 : r == 1 ? 8'hff : 8'($urandom));
      end
   endtask

   task automatic send_chunk(int idx, logic [31:0] tag);
      int r;
      int len;
      r = $urandom_range(0, 99);
      len = chunk_len(idx);
      if (r < 4 && idx != 0) begin
         send_header(idx, len, tag ^ (32'h1 << $urandom_range(0, 31)));
      end else if (r < 8) begin
         send_header(idx, len ^ (1 << $urandom_range(0, 7)), tag);
      end else begin
         // abandoned partial chunk, then the full one
         if (r < 13) begin
            send_header(idx, len, tag);
            send_bytes($urandom_range(1, len - 1));
         end
         send_header(idx, len, tag);
         send_bytes(len);
         if (r >= 96) begin
            send_header(idx, len, tag);
            send_bytes(len);
         end
      end
   endtask

   task automatic run_frame();
      int order [CHUNK_COUNT-1];
      int k;
      int t;
      logic [31:0] tag;
      tag = pick_tag();
      for (int i = 0; i < CHUNK_COUNT - 1; i++) order[i] = i + 1;
      for (int i = CHUNK_COUNT - 2; i > 0; i--) begin
         k = $urandom_range(0, i);
         t = order[i];
         order[i] = order[k];
         order[k] = t;
      end
      send_chunk(0, tag);
      foreach (order[i]) send_chunk(order[i], tag);
   endtask

   task automatic noise_burst();
      int n;
      int idx;
      req_type w;
      n = $urandom_range(3, 12);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
               send_header(idx,
                  ($urandom_range(0, 2) != 0) ? chunk_len(idx) : $urandom_range(0, 255),
                  ($urandom_range(0, 2) != 0) ? sess_gen : pick_tag());
            end
            1: send_byte(8'($urandom));
            2: send_read(written_addr());
            default: begin
               w = noise_word(OP_NONE);
               push_word(w);
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (words_taken != words_queued || owed_replies.size() != 0) @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || words_taken == words_sent) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            cur = pending_words.pop_front();
            req_item <= cur.word;
            start <= 1'b1;
            gap_left = cur.gap;
            words_sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic note_mismatch(string field, int want, int got);
      error_count++;
      if (error_count <= 40)
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
   endtask

   // monitor
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got = rsp_item;
            if (owed_replies.size() == 0) begin
               error_count++;
               if (error_count <= 40)
                  $display("%0t: unexpected result, expected none actual %0h", $time, got);
            end else begin
               want = owed_replies.pop_front();
               if (got.status !== want.status) note_mismatch("status", want.status, got.status);
               if (got.read_data !== want.read_data)
                  note_mismatch("read_data", want.read_data, got.read_data);
               if (got.active !== want.active) note_mismatch("active", want.active, got.active);
            end
         end
         if (start && !busy) begin
            if (cur.has_rsp) owed_replies.push_back(cur.rsp);
            words_taken++;
         end
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed words
      calm = 1'b0;
      push_word(noise_word(OP_NONE));
      send_byte(8'h5a);
      send_header(255, 255, 32'h0);
      send_header(CHUNK_COUNT, 0, 32'h0);
      send_header(1, CHUNK_BYTES, 32'h0);
      send_header(0, CHUNK_BYTES - 1, 32'h0);
      send_header(0, CHUNK_BYTES, 32'hffff_ffff);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'ha5);
      send_read(0);
      send_read(1);
      send_read(2);
      send_header(1, CHUNK_BYTES, 32'h0);
      send_byte(8'h3c);
      send_header(0, CHUNK_BYTES, 32'h0);
      send_header(CHUNK_COUNT - 1, chunk_len(CHUNK_COUNT - 1), 32'h0);
      send_header(CHUNK_COUNT - 1, chunk_len(CHUNK_COUNT - 1) - 1, 32'h0);
      send_read(2);
      send_header(0, 0, 32'h0);
      wait_drained();

      // random frames and noise
      while (words_queued < WORD_TARGET) begin
         calm = ($urandom_range(0, 9) < 3);
         if ($urandom_range(0, 99) < 70) run_frame();
         else noise_burst();
         if ($urandom_range(0, 5) == 0) wait_drained();
      end

      wait_drained();
      repeat (4) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
